// ----- rtl/core/tbo_pkg.sv -----
// ============================================================================
// tbo_pkg: shared types and constants for the triangle / cell overlap unit
// Field widths, fixed-point intermediate widths, result codes and
// configuration register indexes.
// ============================================================================
package tbo_pkg;

    // field widths
    localparam int CRD_W      = 24;   // signed Q8.16 coordinate
    localparam int SIZE_W     = 23;   // unsigned cell size
    localparam int TOL_W      = 16;   // tolerance
    localparam int IDX_W      = 6;    // cell index
    localparam int CODE_W     = 4;    // failed test code
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // intermediate widths
    localparam int BMIN_W = 31;       // org + size * index
    localparam int BMAX_W = 32;       // bmin + size
    localparam int DIFF_W = 25;       // vertex difference
    localparam int REL_W  = 28;       // doubled vertex relative to doubled center
    localparam int XP_W   = 50;       // one cross product term
    localparam int NRM_W  = 51;       // plane normal component
    localparam int PROJ_W = 53;       // edge axis product
    localparam int RAD_W  = 48;       // size * |edge component|
    localparam int ECMP_W = 56;       // edge axis compare
    localparam int NH_W   = 25;       // normal high slice
    localparam int NL_W   = 26;       // normal low slice
    localparam int PH_W   = 53;       // high slice * rel
    localparam int PL_W   = 55;       // low slice * rel
    localparam int NA_W   = 50;       // |normal|
    localparam int NAL_W  = 25;       // |normal| low slice
    localparam int DOT_W  = 80;       // plane sums

    typedef logic signed [CRD_W-1:0]  crd_t;
    typedef logic        [SIZE_W-1:0] size_t;
    typedef logic        [TOL_W-1:0]  tol_t;
    typedef logic        [IDX_W-1:0]  idx_t;
    typedef logic        [CODE_W-1:0] code_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

    typedef logic signed [BMIN_W-1:0] bmin_t;
    typedef logic signed [BMAX_W-1:0] bmax_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic        [DIFF_W-1:0] mag_t;
    typedef logic signed [REL_W-1:0]  rel_t;
    typedef logic signed [XP_W-1:0]   xp_t;
    typedef logic signed [NRM_W-1:0]  nrm_t;
    typedef logic signed [PROJ_W-1:0] proj_t;
    typedef logic        [RAD_W-1:0]  rad_t;
    typedef logic signed [PH_W-1:0]   ph_t;
    typedef logic signed [PL_W-1:0]   pl_t;
    typedef logic        [DOT_W-1:0]  dotu_t;
    typedef logic signed [DOT_W-1:0]  dots_t;

    // result codes
    localparam code_t FT_NONE       = 4'd0;
    localparam code_t FT_BBOX_X     = 4'd1;
    localparam code_t FT_BBOX_Y     = 4'd2;
    localparam code_t FT_BBOX_Z     = 4'd3;
    localparam code_t FT_PLANE      = 4'd4;
    localparam code_t FT_EDGE_FIRST = 4'd5;
    localparam code_t FT_EDGE_LAST  = 4'd13;

    // configuration register indexes
    localparam cfg_idx_t CFG_ORIGIN_X    = 3'd0;
    localparam cfg_idx_t CFG_ORIGIN_Y    = 3'd1;
    localparam cfg_idx_t CFG_ORIGIN_Z    = 3'd2;
    localparam cfg_idx_t CFG_CELL_SIZE_X = 3'd3;
    localparam cfg_idx_t CFG_CELL_SIZE_Y = 3'd4;
    localparam cfg_idx_t CFG_CELL_SIZE_Z = 3'd5;
    localparam cfg_idx_t CFG_TOLERANCE   = 3'd6;

    localparam size_t SIZE_RESET = 23'd1024;
    localparam tol_t  TOL_RESET  = 16'd1;

    typedef struct packed {
        crd_t vert_a_x;
        crd_t vert_a_y;
        crd_t vert_a_z;
        crd_t vert_b_x;
        crd_t vert_b_y;
        crd_t vert_b_z;
        crd_t vert_c_x;
        crd_t vert_c_y;
        crd_t vert_c_z;
        idx_t cell_i;
        idx_t cell_j;
        idx_t cell_k;
    } in_word_t;

    typedef struct packed {
        logic  overlap;
        code_t failed_test;
    } out_word_t;

endpackage

// ----- rtl/core/tbo_if.sv -----
// ============================================================================
// tbo_if: stream and configuration channels
// Valid/ready channels for input words, result words and register writes.
// ============================================================================
interface tbo_in_if;
    import tbo_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbo_out_if;
    import tbo_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbo_cfg_if;
    import tbo_pkg::*;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/triangle_box_overlap_sat_unit.sv -----
// ============================================================================
// triangle_box_overlap_sat_unit: triangle against grid cell, separating axes
// Builds the cell box from the grid registers, then runs the bounding box,
// plane and all edge-cross axis tests and reports the first that separates.
// ============================================================================
//
//  channel  | dir | word
//  ---------+-----+------------------------------------------------
//  in_ch    | in  | three vertices (Q8.16) and cell index i, j, k
//  out_ch   | out | overlap flag and first failed test code
//  cfg_ch   | in  | register index and write data, always ready
//
//  One word per cycle sustained while out_ch is ready; seven register
//  stages, the deepest being the split wide multiplies of the plane test.
//  Reset clears the valid bits and origins; sizes and tolerance get reset values.
//  Each stage holds while the one after it is full and cannot move, so a
//  stall on out_ch backs up without loss; empty stages fill in while stalled.
//
module triangle_box_overlap_sat_unit #(
    parameter int GRID_DIM = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    tbo_in_if.sink    in_ch,
    tbo_out_if.source out_ch,
    tbo_cfg_if.sink   cfg_ch
);
    import tbo_pkg::*;

    localparam int N_ST = 7;

    function automatic int nxt(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    function automatic int prv(input int k);
        return (k == 0) ? 2 : k - 1;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    crd_t  org_reg  [3];
    size_t size_reg [3];
    tol_t  tol_reg;
    logic [TOL_W:0] tol2;

    assign cfg_ch.ready = 1'b1;
    assign tol2 = {tol_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                org_reg[a]  <= '0;
                size_reg[a] <= SIZE_RESET;
            end
            tol_reg <= TOL_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_ORIGIN_X:    org_reg[0]  <= crd_t'(cfg_ch.data);
                CFG_ORIGIN_Y:    org_reg[1]  <= crd_t'(cfg_ch.data);
                CFG_ORIGIN_Z:    org_reg[2]  <= crd_t'(cfg_ch.data);
                CFG_CELL_SIZE_X: size_reg[0] <= cfg_ch.data[SIZE_W-1:0];
                CFG_CELL_SIZE_Y: size_reg[1] <= cfg_ch.data[SIZE_W-1:0];
                CFG_CELL_SIZE_Z: size_reg[2] <= cfg_ch.data[SIZE_W-1:0];
                CFG_TOLERANCE:   tol_reg     <= cfg_ch.data[TOL_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valids and advance chain
    // ------------------------------------------------------------------
    logic [N_ST:1]   v_reg;
    logic [N_ST+1:1] en;

    always_comb
    begin
        en[N_ST+1] = out_ch.ready;
        for (int s = N_ST; s >= 1; s--)
            en[s] = !v_reg[s] || en[s+1];
    end

    assign in_ch.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int s = 1; s <= N_ST; s++)
                if (en[s])
                    v_reg[s] <= (s == 1) ? in_ch.valid : v_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: unpack, cell lower corner, grid range
    // ------------------------------------------------------------------
    crd_t  vin  [3][3];
    idx_t  cidx [3];
    bmin_t s1_bmin_next [3];
    logic  s1_out_next;

    crd_t  s1_vt_reg   [3][3];
    bmin_t s1_bmin_reg [3];
    logic  s1_out_reg;

    always_comb
    begin
        vin[0][0] = in_ch.data.vert_a_x;
        vin[0][1] = in_ch.data.vert_a_y;
        vin[0][2] = in_ch.data.vert_a_z;
        vin[1][0] = in_ch.data.vert_b_x;
        vin[1][1] = in_ch.data.vert_b_y;
        vin[1][2] = in_ch.data.vert_b_z;
        vin[2][0] = in_ch.data.vert_c_x;
        vin[2][1] = in_ch.data.vert_c_y;
        vin[2][2] = in_ch.data.vert_c_z;
        cidx[0]   = in_ch.data.cell_i;
        cidx[1]   = in_ch.data.cell_j;
        cidx[2]   = in_ch.data.cell_k;
    end

    always_comb
    begin
        bmin_t sz_e;
        bmin_t ix_e;
        s1_out_next = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            sz_e = BMIN_W'($signed({1'b0, size_reg[a]}));
            ix_e = BMIN_W'($signed({1'b0, cidx[a]}));
            s1_bmin_next[a] = BMIN_W'(org_reg[a]) + sz_e * ix_e;
            if (int'(cidx[a]) >= GRID_DIM)
                s1_out_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_vt_reg   <= vin;
            s1_bmin_reg <= s1_bmin_next;
            s1_out_reg  <= s1_out_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: bounding box test, doubled center, edge vectors
    // ------------------------------------------------------------------
    code_t s2_bb_next;
    rel_t  s2_ctr2_next [3];
    diff_t s2_f_next    [3][3];
    diff_t s2_g_next    [3];

    crd_t  s2_vt_reg   [3][3];
    rel_t  s2_ctr2_reg [3];
    diff_t s2_f_reg    [3][3];
    diff_t s2_g_reg    [3];
    code_t s2_bb_reg;
    logic  s2_out_reg;

    always_comb
    begin
        bmax_t bmax;
        bmax_t ctr2;
        crd_t  mn;
        crd_t  mx;
        logic signed [BMAX_W:0] hi_lim;
        logic signed [BMAX_W:0] lo_lim;
        logic [2:0] sep;
        for (int a = 0; a < 3; a++)
        begin
            bmax = BMAX_W'(s1_bmin_reg[a]) + BMAX_W'($signed({1'b0, size_reg[a]}));
            mn = s1_vt_reg[0][a];
            mx = s1_vt_reg[0][a];
            for (int k = 1; k < 3; k++)
            begin
                if (s1_vt_reg[k][a] < mn) mn = s1_vt_reg[k][a];
                if (s1_vt_reg[k][a] > mx) mx = s1_vt_reg[k][a];
            end
            hi_lim = (BMAX_W+1)'(bmax) + (BMAX_W+1)'($signed({1'b0, tol_reg}));
            lo_lim = (BMAX_W+1)'(s1_bmin_reg[a]) - (BMAX_W+1)'($signed({1'b0, tol_reg}));
            sep[a] = ((BMAX_W+1)'(mn) > hi_lim) || ((BMAX_W+1)'(mx) < lo_lim);
            // only the low bits matter once the box test has passed
            ctr2 = BMAX_W'(s1_bmin_reg[a]) + bmax;
            s2_ctr2_next[a] = $signed(ctr2[REL_W-1:0]);
            s2_g_next[a] = DIFF_W'(s1_vt_reg[2][a]) - DIFF_W'(s1_vt_reg[0][a]);
            for (int k = 0; k < 3; k++)
                s2_f_next[k][a] = DIFF_W'(s1_vt_reg[nxt(k)][a]) - DIFF_W'(s1_vt_reg[k][a]);
        end
        if (sep[0])
            s2_bb_next = FT_BBOX_X;
        else if (sep[1])
            s2_bb_next = FT_BBOX_Y;
        else if (sep[2])
            s2_bb_next = FT_BBOX_Z;
        else
            s2_bb_next = FT_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_vt_reg   <= s1_vt_reg;
            s2_ctr2_reg <= s2_ctr2_next;
            s2_f_reg    <= s2_f_next;
            s2_g_reg    <= s2_g_next;
            s2_bb_reg   <= s2_bb_next;
            s2_out_reg  <= s1_out_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: relative doubled vertices, normal cross terms
    // ------------------------------------------------------------------
    rel_t s3_v2_next [3][3];
    xp_t  s3_c0_next [3];
    xp_t  s3_c1_next [3];

    rel_t  s3_v2_reg [3][3];
    xp_t   s3_c0_reg [3];
    xp_t   s3_c1_reg [3];
    diff_t s3_f_reg  [3][3];
    code_t s3_bb_reg;
    logic  s3_out_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            for (int a = 0; a < 3; a++)
                s3_v2_next[k][a] = REL_W'($signed({s2_vt_reg[k][a], 1'b0}))
                                 - s2_ctr2_reg[a];
        // n = (b - a) x (c - a)
        for (int a = 0; a < 3; a++)
        begin
            s3_c0_next[a] = XP_W'(s2_f_reg[0][nxt(a)]) * XP_W'(s2_g_reg[prv(a)]);
            s3_c1_next[a] = XP_W'(s2_f_reg[0][prv(a)]) * XP_W'(s2_g_reg[nxt(a)]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_v2_reg  <= s3_v2_next;
            s3_c0_reg  <= s3_c0_next;
            s3_c1_reg  <= s3_c1_next;
            s3_f_reg   <= s2_f_reg;
            s3_bb_reg  <= s2_bb_reg;
            s3_out_reg <= s2_out_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: normal, edge axis projection and radius products
    // ------------------------------------------------------------------
    nrm_t  s4_n_next [3];
    rel_t  s4_w_next [3];
    proj_t s4_pa_next [3][3][2];
    proj_t s4_pb_next [3][3][2];
    rad_t  s4_r0_next [3][3];
    rad_t  s4_r1_next [3][3];

    nrm_t  s4_n_reg  [3];
    rel_t  s4_w_reg  [3];
    proj_t s4_pa_reg [3][3][2];
    proj_t s4_pb_reg [3][3][2];
    rad_t  s4_r0_reg [3][3];
    rad_t  s4_r1_reg [3][3];
    code_t s4_bb_reg;
    logic  s4_out_reg;

    always_comb
    begin
        mag_t fa [3][3];
        int   p;
        int   q;
        int   kv;
        for (int a = 0; a < 3; a++)
        begin
            s4_n_next[a] = NRM_W'(s3_c0_reg[a]) - NRM_W'(s3_c1_reg[a]);
            s4_w_next[a] = -s3_v2_reg[0][a];
        end
        for (int j = 0; j < 3; j++)
            for (int a = 0; a < 3; a++)
                fa[j][a] = s3_f_reg[j][a][DIFF_W-1] ? mag_t'(-s3_f_reg[j][a])
                                                    : mag_t'(s3_f_reg[j][a]);
        // axis e_i x f_j; vertices j and j+1 project alike, so j and j-1 suffice
        for (int i = 0; i < 3; i++)
        begin
            p = nxt(i);
            q = prv(i);
            for (int j = 0; j < 3; j++)
            begin
                for (int t = 0; t < 2; t++)
                begin
                    kv = (t == 0) ? j : prv(j);
                    s4_pa_next[i][j][t] = PROJ_W'(s3_f_reg[j][q]) * PROJ_W'(s3_v2_reg[kv][p]);
                    s4_pb_next[i][j][t] = PROJ_W'(s3_f_reg[j][p]) * PROJ_W'(s3_v2_reg[kv][q]);
                end
                s4_r0_next[i][j] = RAD_W'(size_reg[p]) * RAD_W'(fa[j][q]);
                s4_r1_next[i][j] = RAD_W'(size_reg[q]) * RAD_W'(fa[j][p]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_n_reg   <= s4_n_next;
            s4_w_reg   <= s4_w_next;
            s4_pa_reg  <= s4_pa_next;
            s4_pb_reg  <= s4_pb_next;
            s4_r0_reg  <= s4_r0_next;
            s4_r1_reg  <= s4_r1_next;
            s4_bb_reg  <= s3_bb_reg;
            s4_out_reg <= s3_out_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: edge axis decisions, plane partial products
    // ------------------------------------------------------------------
    logic [8:0] s5_edge_next;
    ph_t  s5_ph_next [3];
    pl_t  s5_pl_next [3];
    rad_t s5_eh_next [3];
    rad_t s5_el_next [3];

    logic [8:0] s5_edge_reg;
    ph_t   s5_ph_reg [3];
    pl_t   s5_pl_reg [3];
    rad_t  s5_eh_reg [3];
    rad_t  s5_el_reg [3];
    code_t s5_bb_reg;
    logic  s5_out_reg;

    always_comb
    begin
        logic signed [PROJ_W:0] pk [2];
        logic signed [PROJ_W:0] lo;
        logic signed [PROJ_W:0] hi;
        logic signed [ECMP_W-1:0] rt;
        logic [NA_W-1:0] an;
        logic signed [NL_W:0] nl;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                for (int t = 0; t < 2; t++)
                    pk[t] = (PROJ_W+1)'(s4_pb_reg[i][j][t]) - (PROJ_W+1)'(s4_pa_reg[i][j][t]);
                lo = (pk[0] < pk[1]) ? pk[0] : pk[1];
                hi = (pk[0] < pk[1]) ? pk[1] : pk[0];
                rt = $signed(ECMP_W'(s4_r0_reg[i][j]) + ECMP_W'(s4_r1_reg[i][j])
                             + ECMP_W'(tol2));
                s5_edge_next[i*3+j] = (ECMP_W'(lo) > rt) || (ECMP_W'(hi) < -rt);
            end
        // normal split in two slices to keep each multiply narrow
        for (int a = 0; a < 3; a++)
        begin
            nl = $signed({1'b0, s4_n_reg[a][NL_W-1:0]});
            s5_ph_next[a] = PH_W'($signed(s4_n_reg[a][NRM_W-1:NL_W])) * PH_W'(s4_w_reg[a]);
            s5_pl_next[a] = PL_W'(nl) * PL_W'(s4_w_reg[a]);
            an = s4_n_reg[a][NRM_W-1] ? NA_W'(-s4_n_reg[a]) : NA_W'(s4_n_reg[a]);
            s5_eh_next[a] = RAD_W'(size_reg[a]) * RAD_W'(an[NA_W-1:NAL_W]);
            s5_el_next[a] = RAD_W'(size_reg[a]) * RAD_W'(an[NAL_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_edge_reg <= s5_edge_next;
            s5_ph_reg   <= s5_ph_next;
            s5_pl_reg   <= s5_pl_next;
            s5_eh_reg   <= s5_eh_next;
            s5_el_reg   <= s5_el_next;
            s5_bb_reg   <= s4_bb_reg;
            s5_out_reg  <= s4_out_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: plane distance and radius sums
    // ------------------------------------------------------------------
    dots_t s6_s_next;
    dotu_t s6_e_next;

    dots_t s6_s_reg;
    dotu_t s6_e_reg;
    logic [8:0] s6_edge_reg;
    code_t s6_bb_reg;
    logic  s6_out_reg;

    always_comb
    begin
        s6_s_next = '0;
        s6_e_next = DOT_W'(tol2);
        for (int a = 0; a < 3; a++)
        begin
            s6_s_next = s6_s_next + (DOT_W'(s5_ph_reg[a]) <<< NL_W) + DOT_W'(s5_pl_reg[a]);
            s6_e_next = s6_e_next + (DOT_W'(s5_eh_reg[a]) << NAL_W) + DOT_W'(s5_el_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_s_reg    <= s6_s_next;
            s6_e_reg    <= s6_e_next;
            s6_edge_reg <= s5_edge_reg;
            s6_bb_reg   <= s5_bb_reg;
            s6_out_reg  <= s5_out_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: plane decision and first failing test
    // ------------------------------------------------------------------
    out_word_t s7_next;
    out_word_t s7_reg;

    always_comb
    begin
        dotu_t abs_s;
        logic  plane_sep;
        code_t edge_code;
        abs_s = s6_s_reg[DOT_W-1] ? dotu_t'(-s6_s_reg) : dotu_t'(s6_s_reg);
        plane_sep = abs_s > s6_e_reg;
        edge_code = FT_NONE;
        for (int x = 8; x >= 0; x--)
            if (s6_edge_reg[x])
                edge_code = FT_EDGE_FIRST + CODE_W'(x);
        s7_next.overlap = 1'b0;
        if (s6_out_reg)
            s7_next.failed_test = FT_NONE;
        else if (s6_bb_reg != FT_NONE)
            s7_next.failed_test = s6_bb_reg;
        else if (plane_sep)
            s7_next.failed_test = FT_PLANE;
        else if (edge_code != FT_NONE)
            s7_next.failed_test = edge_code;
        else
        begin
            s7_next.failed_test = FT_NONE;
            s7_next.overlap     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
            s7_reg <= s7_next;
    end

    assign out_ch.valid = v_reg[N_ST];
    assign out_ch.data  = s7_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> ($countones(v_reg) == N_ST))
        else $error("input stalled with an empty stage");

    a_overlap_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.overlap |-> out_ch.data.failed_test == FT_NONE)
        else $error("overlap reported with a failed test");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.failed_test <= FT_EDGE_LAST)
        else $error("failed test code out of range");

endmodule
